/* rtl/sssc_pkg.sv */
// Shared types, constants and step table of the sensorless six-step commutator.
package sssc_pkg;

  localparam logic signed [7:0] SETTLE_GOAL = 8'sd30;
  localparam logic signed [8:0] SETTLE_UP   = 9'sd3;
  localparam logic signed [8:0] SETTLE_DOWN = 9'sd1;
  localparam logic signed [8:0] COUNT_MAX   = 9'sd127;
  localparam logic signed [8:0] COUNT_MIN   = -9'sd128;

  localparam int CFG_AW = 3;

  localparam logic REG_MAX_COMPARE    = 1'b0;
  localparam logic REG_POWER_FRACTION = 1'b1;

  localparam logic [1:0] PH_NONE = 2'd0;
  localparam logic [1:0] PH_A    = 2'd1;
  localparam logic [1:0] PH_B    = 2'd2;
  localparam logic [1:0] PH_C    = 2'd3;

  localparam logic [1:0] EDGE_NONE = 2'd0;
  localparam logic [1:0] EDGE_RISE = 2'd1;
  localparam logic [1:0] EDGE_FALL = 2'd2;

  localparam logic [2:0] STEP_AB = 3'd0;
  localparam logic [2:0] STEP_AC = 3'd1;
  localparam logic [2:0] STEP_BC = 3'd2;
  localparam logic [2:0] STEP_BA = 3'd3;
  localparam logic [2:0] STEP_CA = 3'd4;
  localparam logic [2:0] STEP_CB = 3'd5;

  typedef struct packed {
    logic comp_a;
    logic comp_b;
    logic comp_c;
    logic force_commutate;
  } sample_t;

  typedef struct packed {
    logic [1:0]  high_phase;
    logic [1:0]  low_phase;
    logic [15:0] pwm_compare;
    logic [2:0]  step_index;
    logic        settling;
    logic        commutated;
  } result_t;

  typedef struct packed {
    logic [15:0] max_compare;
    logic [15:0] power_fraction;
  } cfg_t;

  typedef struct packed {
    logic [1:0] deb_comp;
    logic [1:0] high;
    logic [1:0] low;
    logic [1:0] arm_comp;
    logic [1:0] arm_edge;
    logic [2:0] next_step;
  } step_entry_t;

  function automatic step_entry_t step_lookup(logic [2:0] step);
    step_entry_t e;
    unique case (step)
      STEP_AB: e = '{PH_A, PH_A, PH_B, PH_C, EDGE_FALL, STEP_AC};
      STEP_AC: e = '{PH_C, PH_A, PH_C, PH_B, EDGE_RISE, STEP_BC};
      STEP_BC: e = '{PH_B, PH_B, PH_C, PH_A, EDGE_FALL, STEP_BA};
      STEP_BA: e = '{PH_A, PH_B, PH_A, PH_C, EDGE_RISE, STEP_CA};
      STEP_CA: e = '{PH_C, PH_C, PH_A, PH_B, EDGE_FALL, STEP_CB};
      STEP_CB: e = '{PH_B, PH_C, PH_B, PH_A, EDGE_RISE, STEP_AB};
      3'd6:    e = '{PH_A, PH_A, PH_B, PH_C, EDGE_FALL, STEP_AC};
      default: e = '{PH_C, PH_A, PH_C, PH_B, EDGE_RISE, STEP_BC};
    endcase
    return e;
  endfunction

  function automatic logic level_of(logic [2:0] levels, logic [1:0] phase);
    logic lvl;
    unique case (phase)
      PH_A:    lvl = levels[0];
      PH_B:    lvl = levels[1];
      PH_C:    lvl = levels[2];
      default: lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage

/* rtl/sssc_sample_if.sv */
// Input channel carrying comparator levels and the start request.
interface sssc_sample_if
  import sssc_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sssc_result_if.sv */
// Output channel carrying the drive state of each tick.
interface sssc_result_if
  import sssc_pkg::*;
;
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/sensorless_six_step_commutator_top.sv */
// Sensorless six-step commutator: zero-crossing trigger, debounce and drive table.
// The block takes one sample beat of comparator levels per clock and returns one result beat
// for each, from an output register the cycle after acceptance; a new sample is taken in every
// cycle while the result register is empty or being drained. Edge detection, the signed
// debounce count, the step table and the 16x16 compare product all sit in one pass between
// the state registers and the result register. Registers are written over APB and sampled
// only on the tick a commutation happens. No start-up pass after reset.
module sensorless_six_step_commutator_top
  import sssc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  sssc_sample_if.sink          sample,
  sssc_result_if.source        result
);

  cfg_t cfg;

  logic [2:0]        step_reg;
  logic [1:0]        armed_comparator;
  logic [1:0]        armed_edge;
  logic [2:0]        previous_levels;
  logic              settle_active;
  logic signed [7:0] settle_count;
  logic [1:0]        drive_high;
  logic [1:0]        drive_low;
  logic [15:0]       drive_compare;
  logic              out_valid;
  result_t           out_data;

  logic [2:0]        step_reg_next;
  logic [1:0]        armed_comparator_next;
  logic [1:0]        armed_edge_next;
  logic              settle_active_next;
  logic signed [7:0] settle_count_next;
  logic [1:0]        drive_high_next;
  logic [1:0]        drive_low_next;
  logic [15:0]       drive_compare_next;
  logic              commut;

  logic [2:0]        levels;
  logic              accept;
  logic              edge_armed;
  logic              prev_lvl;
  logic              cur_lvl;
  logic              trig;
  logic              active_now;
  logic              expected;
  logic signed [8:0] count_base;
  logic signed [8:0] count_step;
  logic signed [8:0] count_sat;
  logic [31:0]       product;
  step_entry_t       entry;

  sssc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign sample.ready = !out_valid || result.ready;
  assign accept       = sample.valid && sample.ready;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign levels  = {sample.data.comp_c, sample.data.comp_b, sample.data.comp_a};
  assign entry   = step_lookup(step_reg);
  assign product = 32'(cfg.max_compare) * 32'(cfg.power_fraction);

  always_comb begin
    edge_armed = (armed_comparator != PH_NONE) &&
                 (armed_edge == EDGE_RISE || armed_edge == EDGE_FALL);
    prev_lvl   = level_of(previous_levels, armed_comparator);
    cur_lvl    = level_of(levels, armed_comparator);
    trig       = !settle_active &&
                 (sample.data.force_commutate ||
                  (edge_armed && armed_edge == EDGE_RISE && !prev_lvl && cur_lvl) ||
                  (edge_armed && armed_edge == EDGE_FALL && prev_lvl && !cur_lvl));
    active_now = settle_active || trig;
    expected   = (armed_comparator == entry.deb_comp) && (armed_edge == EDGE_RISE);

    count_base = trig ? 9'sd0 : {settle_count[7], settle_count};
    if (level_of(levels, entry.deb_comp) == expected) begin
      count_step = count_base + SETTLE_UP;
      count_sat  = (count_step > COUNT_MAX) ? COUNT_MAX : count_step;
    end else begin
      count_step = count_base - SETTLE_DOWN;
      count_sat  = (count_step < COUNT_MIN) ? COUNT_MIN : count_step;
    end

    step_reg_next         = step_reg;
    armed_comparator_next = armed_comparator;
    armed_edge_next       = armed_edge;
    settle_active_next    = active_now;
    settle_count_next     = active_now ? count_sat[7:0] : settle_count;
    drive_high_next       = drive_high;
    drive_low_next        = drive_low;
    drive_compare_next    = drive_compare;
    commut                = 1'b0;

    if (active_now && count_sat >= 9'(SETTLE_GOAL)) begin
      drive_high_next       = entry.high;
      drive_low_next        = entry.low;
      drive_compare_next    = product[31:16];
      armed_comparator_next = entry.arm_comp;
      armed_edge_next       = entry.arm_edge;
      step_reg_next         = entry.next_step;
      settle_active_next    = 1'b0;
      settle_count_next     = '0;
      commut                = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg         <= STEP_AB;
      armed_comparator <= PH_NONE;
      armed_edge       <= EDGE_NONE;
      previous_levels  <= '0;
      settle_active    <= 1'b0;
      settle_count     <= '0;
      drive_high       <= PH_NONE;
      drive_low        <= PH_NONE;
      drive_compare    <= '0;
    end else if (accept) begin
      step_reg         <= step_reg_next;
      armed_comparator <= armed_comparator_next;
      armed_edge       <= armed_edge_next;
      previous_levels  <= levels;
      settle_active    <= settle_active_next;
      settle_count     <= settle_count_next;
      drive_high       <= drive_high_next;
      drive_low        <= drive_low_next;
      drive_compare    <= drive_compare_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.high_phase  <= drive_high_next;
      out_data.low_phase   <= drive_low_next;
      out_data.pwm_compare <= (drive_high_next != PH_NONE) ? drive_compare_next : 16'd0;
      out_data.step_index  <= step_reg_next;
      out_data.settling    <= settle_active_next;
      out_data.commutated  <= commut;
    end
  end

  a_settle_below_goal: assert property (@(posedge clk) disable iff (rst)
    settle_active |-> (settle_count < SETTLE_GOAL))
    else $error("debounce count left at or above goal while settling");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    step_reg <= STEP_CB)
    else $error("step register out of range");

  a_drive_pair: assert property (@(posedge clk) disable iff (rst)
    (drive_high != PH_NONE) |-> (drive_low != PH_NONE && drive_low != drive_high))
    else $error("high and low side drive not a valid phase pair");

  a_commut_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && commut) |=> (step_reg != $past(step_reg) && !settle_active))
    else $error("commutation did not advance the step");

endmodule

/* rtl/sssc_cfg_regs.sv */
// APB register block holding full-scale compare and power fraction.
module sssc_cfg_regs
  import sssc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_index;

  assign reg_index = paddr[2];
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        REG_MAX_COMPARE:    cfg.max_compare    <= pwdata[15:0];
        REG_POWER_FRACTION: cfg.power_fraction <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_MAX_COMPARE:    prdata = {16'd0, cfg.max_compare};
      REG_POWER_FRACTION: prdata = {16'd0, cfg.power_fraction};
      default:            prdata = '0;
    endcase
  end

endmodule
